/* hw/rtl/esnv_pkg.sv */
// Shared constants and types for the echo subtract, noise gate and VAD block.
package esnv_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int FRAME_MAX    = 1024;
  localparam int CNT_W        = $clog2(FRAME_MAX + 1);
  // Sum of up to FRAME_MAX magnitudes of at most 2^15 each.
  localparam int SUM_W        = CNT_W + 15;
  localparam int TOTAL_W      = 32;
  localparam int NOISE_W      = 16;
  localparam int SPEECH_SHIFT = 8;

  localparam logic [NOISE_W-1:0] NOISE_RESET  = NOISE_W'(32);
  localparam logic [NOISE_W:0]   QUIET_MARGIN = (NOISE_W + 1)'(24);

  typedef enum logic [1:0] {
    CFG_ECHO  = 2'd0,
    CFG_NOISE = 2'd1,
    CFG_VAD   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic               dec_valid;
    logic               speech;
    logic [TOTAL_W-1:0] speech_total;
    logic [TOTAL_W-1:0] silence_total;
    logic               oversize;
  } vad_res_t;

endpackage

/* hw/rtl/esnv_gate.sv */
// Echo subtraction, noise level tracking, quiet-sample attenuation and clamp.
module esnv_gate
  import esnv_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       echo_en,
  input  logic                       noise_en,
  input  logic signed [SAMPLE_W-1:0] mic,
  input  logic signed [SAMPLE_W-1:0] ref_smp,
  input  logic                       ref_valid,
  output logic signed [SAMPLE_W-1:0] sample
);

  logic [NOISE_W-1:0]         noise_level_r;
  logic [NOISE_W-1:0]         noise_level_nxt;
  logic signed [SAMPLE_W-1:0] ref_q;
  logic signed [SAMPLE_W:0]   v_echo;
  logic signed [SAMPLE_W:0]   v_quart;
  logic signed [SAMPLE_W:0]   v_gate;
  logic [NOISE_W-1:0]         v_mag;
  logic [20:0]                lvl_sum;
  logic                       quiet;

  // Divide by 4 rounding toward zero: bias negatives by 3 before the shift.
  assign ref_q   = (ref_smp +
                    $signed(SAMPLE_W'({ref_smp[SAMPLE_W-1], ref_smp[SAMPLE_W-1]}))) >>> 2;
  assign v_echo  = (echo_en && ref_valid) ?
                   (SAMPLE_W+1)'(mic) - (SAMPLE_W+1)'(ref_q) : (SAMPLE_W+1)'(mic);
  assign v_mag   = v_echo[SAMPLE_W] ? NOISE_W'(-v_echo) : NOISE_W'(v_echo);

  // level*15 + |v|, then drop four bits
  assign lvl_sum = ({1'b0, noise_level_r, 4'b0} - {5'b0, noise_level_r}) + {5'b0, v_mag};
  assign noise_level_nxt = lvl_sum[NOISE_W+3:4];
  assign quiet   = {1'b0, v_mag} < ({1'b0, noise_level_nxt} + QUIET_MARGIN);

  assign v_quart = (v_echo +
                    $signed((SAMPLE_W+1)'({v_echo[SAMPLE_W], v_echo[SAMPLE_W]}))) >>> 2;
  assign v_gate  = (noise_en && quiet) ? v_quart : v_echo;

  always_comb begin
    unique case (v_gate[SAMPLE_W:SAMPLE_W-1])
      2'b01:   sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
      2'b10:   sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      default: sample = v_gate[SAMPLE_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_level_r <= NOISE_RESET;
    end else if (adv && noise_en) begin
      noise_level_r <= noise_level_nxt;
    end
  end

`ifndef SYNTHESIS
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && noise_en) |=> $stable(noise_level_r))
    else $error("noise level moved without an accepted request");
`endif

endmodule

/* hw/rtl/esnv_vad.sv */
// Frame accumulation, speech decision and speech/silence frame counters.
module esnv_vad
  import esnv_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       vad_en,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  output vad_res_t                   res
);

  logic [CNT_W-1:0]   frame_count_r;
  logic [CNT_W-1:0]   frame_count_nxt;
  logic [SUM_W-1:0]   abs_sum_r;
  logic [SUM_W-1:0]   abs_sum_nxt;
  logic [TOTAL_W-1:0] speech_total_r;
  logic [TOTAL_W-1:0] speech_total_nxt;
  logic [TOTAL_W-1:0] silence_total_r;
  logic [TOTAL_W-1:0] silence_total_nxt;
  logic               overflow_r;
  logic               overflow_nxt;
  logic [SAMPLE_W-1:0] s_mag;
  logic               counted;
  logic               decide;
  logic               speech;

  assign s_mag   = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
  assign counted = frame_count_r < CNT_W'(FRAME_MAX);

  assign frame_count_nxt = counted ? frame_count_r + CNT_W'(1) : frame_count_r;
  assign abs_sum_nxt     = counted ? abs_sum_r + SUM_W'(s_mag) : abs_sum_r;
  assign overflow_nxt    = overflow_r | ~counted;

  assign decide = last && vad_en;
  assign speech = decide &&
                  (abs_sum_nxt >= SUM_W'({frame_count_nxt, {SPEECH_SHIFT{1'b0}}}));

  assign speech_total_nxt  = (decide && speech)  ? speech_total_r + TOTAL_W'(1)
                                                 : speech_total_r;
  assign silence_total_nxt = (decide && !speech) ? silence_total_r + TOTAL_W'(1)
                                                 : silence_total_r;

  always_comb begin
    res.dec_valid     = decide;
    res.speech        = speech;
    res.speech_total  = speech_total_nxt;
    res.silence_total = silence_total_nxt;
    res.oversize      = overflow_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r   <= '0;
      abs_sum_r       <= '0;
      overflow_r      <= 1'b0;
      speech_total_r  <= '0;
      silence_total_r <= '0;
    end else if (adv) begin
      speech_total_r  <= speech_total_nxt;
      silence_total_r <= silence_total_nxt;
      // clear the frame after its last sample
      if (last) begin
        frame_count_r <= '0;
        abs_sum_r     <= '0;
        overflow_r    <= 1'b0;
      end else begin
        frame_count_r <= frame_count_nxt;
        abs_sum_r     <= abs_sum_nxt;
        overflow_r    <= overflow_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_count_r <= CNT_W'(FRAME_MAX))
    else $error("frame count beyond maximum frame length");
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last |=> frame_count_r == '0 && abs_sum_r == '0 && !overflow_r)
    else $error("frame state not cleared after frame end");
  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && decide) |=> $stable(speech_total_r) && $stable(silence_total_r))
    else $error("frame totals moved without a decision");
`endif

endmodule

/* hw/rtl/echo_subtract_noise_gate_vad.sv */
// Top level: echo subtraction, noise gate and frame voice-activity detector.
//
// Input stream: one mic sample and one reference sample per request; in_tuser
// flags a valid reference, in_tlast marks the last sample of a frame.
// Output stream: one result per input request, in order. out_tlast repeats
// the frame end; out_tuser carries the speech decision and the oversize flag;
// out_tdata carries the processed sample and the running frame totals.
// Configuration: cfg_we writes bit 0 of cfg_wdata into register cfg_index
// (0 echo enable, 1 noise enable, 2 VAD enable); unused indexes are ignored.
// Path: an accepted request is held in the input register, then moves to the
// output register. Throughput: one request per cycle while out_tready is high;
// the whole computation sits between the input and the output register.
// Stall: while out_tready is low the result holds and the input register
// takes one more request, then in_tready drops until the output drains.
// Reset (rst_n low, synchronous) clears both stages, the enables, the frame
// state and the totals, and sets the noise level to 32.
module echo_subtract_noise_gate_vad
  import esnv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic         cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [15:0] mic_sample, [31:16] ref_sample
  input  logic         in_tuser,   // [0] ref_valid
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,  // [15:0] sample_out, [47:16] speech_frames,
                                   // [79:48] silence_frames
  output logic [2:0]   out_tuser,  // [0] vad_valid, [1] speech_flag, [2] oversize
  output logic         out_tlast
);

  logic                echo_en_r;
  logic                noise_en_r;
  logic                vad_en_r;
  logic                in_valid_r;
  logic [SAMPLE_W-1:0] mic_r;
  logic [SAMPLE_W-1:0] ref_r;
  logic                ref_valid_r;
  logic                last_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] sample_out_r;
  logic                out_last_r;
  vad_res_t            vad_r;
  logic                adv;
  logic                in_take;
  logic signed [SAMPLE_W-1:0] gate_sample;
  vad_res_t            vad_res;

  // advance the held request into the output register
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_en_r  <= 1'b0;
      noise_en_r <= 1'b0;
      vad_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ECHO:  echo_en_r  <= cfg_wdata;
        CFG_NOISE: noise_en_r <= cfg_wdata;
        CFG_VAD:   vad_en_r   <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mic_r       <= in_tdata[15:0];
      ref_r       <= in_tdata[31:16];
      ref_valid_r <= in_tuser;
      last_r      <= in_tlast;
    end
  end

  esnv_gate u_gate (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .echo_en   (echo_en_r),
    .noise_en  (noise_en_r),
    .mic       ($signed(mic_r)),
    .ref_smp   ($signed(ref_r)),
    .ref_valid (ref_valid_r),
    .sample    (gate_sample)
  );

  esnv_vad u_vad (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vad_en (vad_en_r),
    .sample (gate_sample),
    .last   (last_r),
    .res    (vad_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_out_r <= gate_sample;
      out_last_r   <= last_r;
      vad_r        <= vad_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {vad_r.silence_total, vad_r.speech_total, sample_out_r};
  assign out_tuser  = {vad_r.oversize, vad_r.speech, vad_r.dec_valid};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_decision_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (vad_r.dec_valid || vad_r.speech) |-> out_last_r && vad_r.dec_valid)
    else $error("speech decision outside a frame end");
`endif

endmodule
